/* rtl/hcbp_pkg.sv */
// Shared request codes and channel payload types for the Huffman code bit packer.
package hcbp_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned CodeW    = 32;
  localparam int unsigned LenW     = 6;
  localparam int unsigned SymW     = 8;

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [SymW-1:0]   symbol;
    logic [CodeW-1:0]  code_bits;
    logic [LenW-1:0]   code_length;
  } in_req_t;

  typedef struct packed {
    logic [ByteBits-1:0] out_byte;
    logic                last_in_run;
  } out_rsp_t;

  // Code table entry as seen by the packer; len is zero for a missing code.
  typedef struct packed {
    logic [CodeW-1:0] val;
    logic [LenW-1:0]  len;
  } tbl_rd_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [SymW-1:0]  sym;
    logic [CodeW-1:0] val;
    logic [LenW-1:0]  len;
  } tbl_req_t;

endpackage

/* rtl/hcbp_code_table.sv */
// Code value and length memories with per-entry valid bits and registered read.
module hcbp_code_table import hcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned NUM_SYMBOLS  = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output tbl_rd_t  rd_o
);

  localparam int unsigned IdxW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int unsigned CapLen = (MAX_CODE_LEN < CodeW) ? MAX_CODE_LEN : CodeW;

  logic [CodeW-1:0]       val_mem [NUM_SYMBOLS];
  logic [LenW-1:0]        len_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vld_q;

  logic [IdxW-1:0]  idx;
  logic             in_range;
  logic [LenW-1:0]  len_cap;
  logic [CodeW-1:0] rd_val_q;
  logic [LenW-1:0]  rd_len_q;
  logic             rd_vld_q;

  assign idx      = req_i.sym[IdxW-1:0];
  assign in_range = ({1'b0, req_i.sym} < 9'(NUM_SYMBOLS));
  assign len_cap  = (req_i.len > LenW'(CapLen)) ? LenW'(CapLen) : req_i.len;

  always_ff @(posedge clk_i) begin
    if (req_i.we && in_range) begin
      val_mem[idx] <= req_i.val;
      len_mem[idx] <= len_cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we && in_range) begin
      vld_q[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rd_val_q <= val_mem[idx];
      rd_len_q <= len_mem[idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (req_i.re) begin
      rd_vld_q <= in_range && vld_q[idx];
    end
  end

  assign rd_o.val = rd_val_q;
  assign rd_o.len = rd_vld_q ? rd_len_q : '0;

endmodule

/* rtl/hcbp_packer.sv */
// Bit accumulator, pending byte state and output byte serializer.
module hcbp_packer import hcbp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_acc_i,
  input  req_e     req_type_i,
  input  tbl_rd_t  tbl_rd_i,
  output logic     busy_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int unsigned AccW = 7 + CodeW;

  logic       s1_valid_q, s1_valid_d;
  req_e       s1_type_q;
  logic [6:0] pend_q, pend_d;
  logic [2:0] cnt_q, cnt_d;

  logic        b_valid_q, b_valid_d;
  logic [31:0] b_word_q, b_word_d;
  logic [2:0]  b_cnt_q, b_cnt_d;

  logic [CodeW:0]   code_mask;
  logic [CodeW-1:0] code;
  logic [AccW-1:0]  acc;
  logic [AccW-1:0]  emitted;
  logic [5:0]       total;
  logic [2:0]       enc_nb;
  logic [2:0]       rem;
  logic [3:0]       flush_sh;
  logic [7:0]       flush_byte;
  logic [2:0]       nb;
  logic [31:0]      word;
  logic             out_acc;
  logic             b_free;
  logic             s1_adv;

  always_comb begin
    code_mask = ~({(CodeW+1){1'b1}} << tbl_rd_i.len);
    code      = tbl_rd_i.val & code_mask[CodeW-1:0];
    acc       = (AccW'(pend_q) << tbl_rd_i.len) | AccW'(code);
    total     = 6'({3'b000, cnt_q}) + tbl_rd_i.len;
    enc_nb    = total[5:3];
    rem       = total[2:0];
    emitted   = acc >> rem;
    flush_sh  = 4'd8 - {1'b0, cnt_q};
    flush_byte = 8'({1'b0, pend_q} << flush_sh);

    nb     = '0;
    word   = '0;
    pend_d = pend_q;
    cnt_d  = cnt_q;
    case (s1_type_q)
      REQ_ENCODE: begin
        nb     = enc_nb;
        word   = emitted[31:0] << (6'd32 - {enc_nb, 3'b000});
        pend_d = acc[6:0] & ~(7'h7F << rem);
        cnt_d  = rem;
      end
      REQ_FLUSH: begin
        nb     = (cnt_q != 3'd0) ? 3'd1 : 3'd0;
        word   = {flush_byte, 24'h000000};
        pend_d = '0;
        cnt_d  = '0;
      end
      default: begin
      end
    endcase
  end

  assign out_acc = b_valid_q && !out_stall_i;
  assign b_free  = !b_valid_q || (out_acc && (b_cnt_q == 3'd1));
  assign s1_adv  = s1_valid_q && ((nb == 3'd0) || b_free);
  assign busy_o  = s1_valid_q && !s1_adv;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    b_valid_d = b_valid_q;
    b_word_d  = b_word_q;
    b_cnt_d   = b_cnt_q;
    if (s1_adv && (nb != 3'd0)) begin
      b_valid_d = 1'b1;
      b_word_d  = word;
      b_cnt_d   = nb;
    end else if (out_acc) begin
      b_valid_d = (b_cnt_q != 3'd1);
      b_word_d  = {b_word_q[23:0], 8'h00};
      b_cnt_d   = b_cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_type_q  <= REQ_LOAD;
      pend_q     <= '0;
      cnt_q      <= '0;
      b_valid_q  <= 1'b0;
      b_cnt_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (in_acc_i) begin
        s1_type_q <= req_type_i;
      end
      if (s1_adv) begin
        pend_q <= pend_d;
        cnt_q  <= cnt_d;
      end
      b_valid_q <= b_valid_d;
      b_cnt_q   <= b_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_word_q <= b_word_d;
  end

  assign out_valid_o           = b_valid_q;
  assign out_rsp_o.out_byte    = b_word_q[31:24];
  assign out_rsp_o.last_in_run = (b_cnt_q == 3'd1);

endmodule

/* rtl/huffman_code_bit_packer_core.sv */
// Huffman code bit packer: code table lookup followed by bit packing into bytes.
// A request reads the code table and enters the packer stage at its accept edge; the packer
// stage then loads its bytes into the output byte buffer, which offers the first byte.
// Throughput: one request per cycle while no bytes are due; bytes leave one per cycle unless
// the output stalls; a request with bytes waits until the last byte of the one before is taken.
// Reset clears the pending bits and all table valid bits, so every symbol starts with no code.
module huffman_code_bit_packer_core import hcbp_pkg::*; #(
  parameter int unsigned MAX_CODE_LEN = 32,
  parameter int unsigned NUM_SYMBOLS  = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  logic     in_acc;
  logic     busy;
  req_e     req_type;
  tbl_req_t tbl_req;
  tbl_rd_t  tbl_rd;

  assign in_stall_o = busy;
  assign in_acc     = in_valid_i && !busy;
  assign req_type   = req_e'(in_req_i.req_type);

  always_comb begin
    tbl_req.we  = in_acc && (req_type == REQ_LOAD);
    tbl_req.re  = in_acc && (req_type == REQ_ENCODE);
    tbl_req.sym = in_req_i.symbol;
    tbl_req.val = in_req_i.code_bits;
    tbl_req.len = in_req_i.code_length;
  end

  hcbp_code_table #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (tbl_req),
    .rd_o  (tbl_rd)
  );

  hcbp_packer u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_acc_i   (in_acc),
    .req_type_i (req_type),
    .tbl_rd_i   (tbl_rd),
    .busy_o     (busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule
